// File: hdl/mkrd_pkg.sv
// ----------------------------------------------------------------------------
// mkrd_pkg
// Types and decode tables for the matrix keypad release detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mkrd_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_key;
    typedef logic [7:0] t_count;

    localparam int NUM_MATRIX = 16;
    localparam int NUM_AUX    = 4;
    localparam int NUM_SCAN   = 8;

    localparam t_key   NO_KEY       = 5'd20;
    localparam t_key   AUX_KEY_BASE = 5'd16;
    localparam t_count COUNT_TOP    = 8'd128;
    localparam t_count COUNT_FIRST  = 8'd1;
    localparam t_count MIN_HOLD_RST = 8'd1;
    localparam t_byte  IDLE_NONE    = 8'h0F;
    localparam t_byte  AUX_NONE     = 8'hFF;

    localparam t_byte MATRIX_CODES [NUM_MATRIX] = '{
        8'h77, 8'hB7, 8'hD7, 8'hE7, 8'h7B, 8'hBB, 8'hDB, 8'hEB,
        8'h7D, 8'hBD, 8'hDD, 8'hED, 8'h7E, 8'hBE, 8'hDE, 8'hEE
    };

    localparam t_byte AUX_CODES [NUM_AUX] = '{8'hF7, 8'hFB, 8'hFD, 8'hFE};

    localparam t_byte DRIVE_PATTERNS [NUM_SCAN] = '{
        8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hFE, 8'hFD, 8'hFB, 8'hF7
    };

    // One scan tick as held in the input register
    typedef struct packed {
        logic  int_level;
        t_byte idle_read;
        t_byte [NUM_SCAN-1:0] scan_read;
        t_byte aux_read;
    } t_tick;

endpackage

`default_nettype wire

// File: hdl/mkrd_tick_if.sv
// ----------------------------------------------------------------------------
// mkrd_tick_if
// Valid/ready channel carrying one scan tick of port readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkrd_tick_if;
    logic          valid;
    logic          ready;
    logic          int_level;
    mkrd_pkg::t_byte idle_read;
    mkrd_pkg::t_byte scan_read_0;
    mkrd_pkg::t_byte scan_read_1;
    mkrd_pkg::t_byte scan_read_2;
    mkrd_pkg::t_byte scan_read_3;
    mkrd_pkg::t_byte scan_read_4;
    mkrd_pkg::t_byte scan_read_5;
    mkrd_pkg::t_byte scan_read_6;
    mkrd_pkg::t_byte scan_read_7;
    mkrd_pkg::t_byte aux_read;

    modport source (
        output valid, int_level, idle_read,
        output scan_read_0, scan_read_1, scan_read_2, scan_read_3,
        output scan_read_4, scan_read_5, scan_read_6, scan_read_7,
        output aux_read,
        input  ready
    );

    modport sink (
        input  valid, int_level, idle_read,
        input  scan_read_0, scan_read_1, scan_read_2, scan_read_3,
        input  scan_read_4, scan_read_5, scan_read_6, scan_read_7,
        input  aux_read,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/mkrd_key_if.sv
// ----------------------------------------------------------------------------
// mkrd_key_if
// Valid/ready channel carrying one released key code.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkrd_key_if;
    logic           valid;
    logic           ready;
    mkrd_pkg::t_key key_code;

    modport source (output valid, key_code, input ready);
    modport sink   (input valid, key_code, output ready);
endinterface

`default_nettype wire

// File: hdl/mkrd_decode.sv
// ----------------------------------------------------------------------------
// mkrd_decode
// Table decode of one scan tick into a key number, or NO_KEY.
// ----------------------------------------------------------------------------
`default_nettype none

module mkrd_decode (
    input  mkrd_pkg::t_tick i_tick,
    output mkrd_pkg::t_key  o_key
);

    mkrd_pkg::t_key matrix_key;
    mkrd_pkg::t_key aux_key;
    logic           aux_hit;

    // Later scan patterns take priority; a reading equal to its own drive
    // pattern means nothing pressed on that pattern.
    always_comb begin
        matrix_key = mkrd_pkg::NO_KEY;
        if (i_tick.idle_read != mkrd_pkg::IDLE_NONE) begin
            for (int p = 0; p < mkrd_pkg::NUM_SCAN; p++) begin
                if (i_tick.scan_read[p] != mkrd_pkg::DRIVE_PATTERNS[p]) begin
                    for (int i = 0; i < mkrd_pkg::NUM_MATRIX; i++) begin
                        if (i_tick.scan_read[p] == mkrd_pkg::MATRIX_CODES[i]) begin
                            matrix_key = mkrd_pkg::t_key'(i);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        aux_key = mkrd_pkg::NO_KEY;
        aux_hit = 1'b0;
        if (i_tick.aux_read != mkrd_pkg::AUX_NONE) begin
            for (int i = 0; i < mkrd_pkg::NUM_AUX; i++) begin
                if (i_tick.aux_read == mkrd_pkg::AUX_CODES[i]) begin
                    aux_key = mkrd_pkg::AUX_KEY_BASE + mkrd_pkg::t_key'(i);
                    aux_hit = 1'b1;
                end
            end
        end
    end

    assign o_key = aux_hit ? aux_key : matrix_key;

endmodule

`default_nettype wire

// File: hdl/matrix_keypad_release_detector_top.sv
// ----------------------------------------------------------------------------
// matrix_keypad_release_detector_top
// Arms on the key interrupt, tracks the held key and hold count per scan
// tick, and reports the key on release once held long enough.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_tick     in   valid/ready    int_level, idle_read, scan_read_0..7, aux_read
//  o_key      out  valid/ready    key_code
//  i_cfg_*    in   write enable   min_hold
//
//  One tick per cycle unless stalled. A tick is registered on transfer and
//  decoded from the input register; when it moves on, state is updated and
//  any release is loaded into the output register, which offers the result.
//  Reset clears the armed flag, held key, hold count and min_hold (to 1).
//  A tick that would report stalls in the input register only while the
//  output register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_release_detector_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    mkrd_tick_if.sink       i_tick,
    mkrd_key_if.source      o_key,
    input  wire             i_cfg_we,
    input  mkrd_pkg::t_byte i_cfg_data
);

    logic             r_in_valid;
    mkrd_pkg::t_tick  r_in;
    logic             r_out_valid;
    mkrd_pkg::t_key   r_out_key;
    logic             r_armed;
    mkrd_pkg::t_key   r_held;
    mkrd_pkg::t_count r_count;
    mkrd_pkg::t_count r_min_hold;

    mkrd_pkg::t_key   key_now;
    mkrd_pkg::t_count n_count;
    logic             emit;
    logic             step;
    logic             in_take;

    mkrd_decode u_decode (
        .i_tick (r_in),
        .o_key  (key_now)
    );

    assign emit = r_armed && (key_now == mkrd_pkg::NO_KEY) && (r_count != '0)
                  && (r_count >= r_min_hold) && (r_held < mkrd_pkg::NO_KEY);

    assign step    = r_in_valid && (!emit || !r_out_valid || o_key.ready);
    assign in_take = i_tick.valid && i_tick.ready;

    assign i_tick.ready = !r_in_valid || step;

    assign n_count = (r_count >= mkrd_pkg::COUNT_TOP) ? mkrd_pkg::COUNT_FIRST
                                                      : r_count + 8'd1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.int_level    <= i_tick.int_level;
            r_in.idle_read    <= i_tick.idle_read;
            r_in.scan_read[0] <= i_tick.scan_read_0;
            r_in.scan_read[1] <= i_tick.scan_read_1;
            r_in.scan_read[2] <= i_tick.scan_read_2;
            r_in.scan_read[3] <= i_tick.scan_read_3;
            r_in.scan_read[4] <= i_tick.scan_read_4;
            r_in.scan_read[5] <= i_tick.scan_read_5;
            r_in.scan_read[6] <= i_tick.scan_read_6;
            r_in.scan_read[7] <= i_tick.scan_read_7;
            r_in.aux_read     <= i_tick.aux_read;
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_held  <= mkrd_pkg::NO_KEY;
            r_count <= '0;
        end else if (step) begin
            if (!r_armed) begin
                if (!r_in.int_level) begin
                    r_armed <= 1'b1;
                    r_count <= '0;
                end
            end else begin
                r_held <= key_now;
                if (key_now == mkrd_pkg::NO_KEY) begin
                    r_armed <= 1'b0;
                end else begin
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hold <= mkrd_pkg::MIN_HOLD_RST;
        end else if (i_cfg_we) begin
            r_min_hold <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_key.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_key <= r_held;
        end
    end

    assign o_key.valid    = r_out_valid;
    assign o_key.key_code = r_out_key;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mkrd_pkg::COUNT_TOP)
        else $error("hold count beyond top");

    a_out_key_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_key < mkrd_pkg::NO_KEY))
        else $error("reported key out of range");

    a_release_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit) |=> (!r_armed && r_out_valid
                            && r_held == mkrd_pkg::NO_KEY))
        else $error("release did not disarm and report");

    a_hold_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_armed && key_now != mkrd_pkg::NO_KEY)
            |=> (r_armed && r_count != '0))
        else $error("valid decode did not advance hold count");
`endif

endmodule

`default_nettype wire
